/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property does not hold");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* design/crcx_pkg.sv */
// ----------------------------------------------------------------------------
// crcx_pkg
// Shared constants, types and functions of the escaped CRC-16 block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crcx_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned NibWidth  = 4;

  localparam logic [CrcWidth-1:0]  CrcPoly   = 16'h1021;
  localparam logic [CrcWidth-1:0]  CrcInit   = 16'h0000;
  localparam logic [NibWidth-1:0]  NibMask   = 4'hf;

  // framing characters that must not show up in a CRC byte
  localparam logic [ByteWidth-1:0] FrameParen = 8'h28;
  localparam logic [ByteWidth-1:0] FrameCr    = 8'h0d;
  localparam logic [ByteWidth-1:0] FrameLf    = 8'h0a;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;
  typedef logic [NibWidth-1:0]  nib_t;

  typedef struct packed {
    crc_t folded;   // running value with the byte folded in
    crc_t escaped;  // folded value with both bytes escaped
  } fold_res_t;

  // CRC of one nibble placed at the top of a zero register
  function automatic crc_t nib_table(input nib_t idx);
    crc_t c;
    c = {idx, 12'h000};
    for (int i = 0; i < NibWidth; i++) begin
      if (c[CrcWidth-1]) begin
        c = {c[CrcWidth-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcWidth-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic crc_t nib_step(input crc_t crc, input nib_t nib);
    nib_t idx;
    idx = (crc[CrcWidth-1 -: NibWidth] ^ nib) & NibMask;
    return {crc[CrcWidth-NibWidth-1:0], {NibWidth{1'b0}}} ^ nib_table(idx);
  endfunction

  function automatic byte_t escape_byte(input byte_t b);
    if (b == FrameParen || b == FrameCr || b == FrameLf) begin
      return b + byte_t'(1);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* design/crcx_if.sv */
// ----------------------------------------------------------------------------
// crcx interfaces
// Valid/ready channels for message bytes and escaped CRC results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crcx_msg_if;
  logic                 valid;
  logic                 ready;
  crcx_pkg::byte_t      data_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcx_res_if;
  logic                 valid;
  logic                 ready;
  crcx_pkg::crc_t       crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

/* design/crcx_fold.sv */
// ----------------------------------------------------------------------------
// crcx_fold
// Folds one byte into the running CRC, high nibble first, and escapes both result bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crcx_fold (
  input  var crcx_pkg::crc_t      crc,
  input  var crcx_pkg::byte_t     data_byte,
  output var crcx_pkg::fold_res_t res
);

  crcx_pkg::crc_t mid;
  crcx_pkg::crc_t folded;

  always_comb begin
    mid    = crcx_pkg::nib_step(crc, data_byte[7:4]);
    folded = crcx_pkg::nib_step(mid, data_byte[3:0]);
    res.folded  = folded;
    res.escaped = {crcx_pkg::escape_byte(folded[15:8]),
                   crcx_pkg::escape_byte(folded[7:0])};
  end

endmodule

`default_nettype wire

/* design/crc16_xmodem_escaped.sv */
// ----------------------------------------------------------------------------
// crc16_xmodem_escaped
// Byte-serial CRC-16 (poly 0x1021, init 0) with escaped result bytes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                       | accepted when
//  msg     | in  | data_byte[7:0], last_byte     | msg.valid && msg.ready
//  crc     | out | crc_value[15:0] (hi in 15:8)  | crc.valid && crc.ready
//
//  One byte per cycle unless a stalled result holds a last byte: a byte sits in
//  the input register, then is folded into the running CRC (two nibble table
//  steps) on the way out; a last byte's result then goes to the result register.
//  rst (synchronous) clears the running CRC and both valid flags.
//  A stalled result holds a last byte in the input register, and with it the
//  bytes behind it; non-final bytes ahead of it keep flowing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crc16_xmodem_escaped (
  input  wire        clk,
  input  wire        rst,
  crcx_msg_if.sink   msg,
  crcx_res_if.source crc
);

  // input register
  logic                s1_valid;
  crcx_pkg::byte_t     s1_data;
  logic                s1_last;
  logic                s1_advance;

  crcx_pkg::crc_t      running_crc;
  crcx_pkg::fold_res_t fold;

  // result register
  logic                out_valid;
  crcx_pkg::crc_t      out_crc;

  crcx_fold u_fold (
    .crc       (running_crc),
    .data_byte (s1_data),
    .res       (fold)
  );

  // a non-final byte needs no result slot
  assign s1_advance = s1_valid && (!s1_last || !out_valid || crc.ready);
  assign msg.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      s1_data <= msg.data_byte;
      s1_last <= msg.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= crcx_pkg::CrcInit;
    end else if (s1_advance) begin
      running_crc <= s1_last ? crcx_pkg::CrcInit : fold.folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (crc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      out_crc <= fold.escaped;
    end
  end

  assign crc.valid     = out_valid;
  assign crc.crc_value = out_crc;

  `ASSERT_HOLDS(a_clear_after_end, clk, rst,
    (s1_advance && s1_last) |=> (running_crc == crcx_pkg::CrcInit))
  `ASSERT_NEVER(a_no_frame_low, clk, rst,
    out_valid && (out_crc[7:0] == crcx_pkg::FrameParen ||
    out_crc[7:0] == crcx_pkg::FrameCr || out_crc[7:0] == crcx_pkg::FrameLf))
  `ASSERT_NEVER(a_no_frame_high, clk, rst,
    out_valid && (out_crc[15:8] == crcx_pkg::FrameParen ||
    out_crc[15:8] == crcx_pkg::FrameCr || out_crc[15:8] == crcx_pkg::FrameLf))
  `ASSERT_HOLDS(a_stage_holds, clk, rst,
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_data) && $stable(running_crc)))

endmodule

`default_nettype wire
